@@ src/i2cmts_pkg.sv @@
// shared types and codes for the i2c master transaction sequencer
package i2cmts_pkg;

	// sequencer mode
	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_TX    = 2'd1,
		MODE_RADDR = 2'd2,
		MODE_RX    = 2'd3
	} mode_t;

	// input opcodes
	localparam logic OP_QUEUE = 1'b0;
	localparam logic OP_EVENT = 1'b1;

	// bus command codes
	localparam logic [1:0] BUS_NONE   = 2'd0;
	localparam logic [1:0] BUS_STOP   = 2'd1;
	localparam logic [1:0] BUS_RSTART = 2'd2;

	// direction codes
	localparam logic [1:0] DIR_KEEP = 2'd0;
	localparam logic [1:0] DIR_TX   = 2'd1;
	localparam logic [1:0] DIR_RX   = 2'd2;

	// acknowledge codes
	localparam logic [1:0] ACK_KEEP = 2'd0;
	localparam logic [1:0] ACK_ACK  = 2'd1;
	localparam logic [1:0] ACK_NACK = 2'd2;

	// transaction descriptor
	typedef struct packed {
		logic       stop_after;
		logic [7:0] length;
		logic       is_read;
		logic [6:0] address;
	} desc_t;

	// input word
	typedef struct packed {
		logic       opcode;
		logic [6:0] address;
		logic       is_read;
		logic [7:0] length;
		logic       stop_after;
		logic       nack_seen;
		logic [7:0] rx_data;
		logic [7:0] tx_data;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [1:0] bus_cmd;
		logic       data_out_valid;
		logic [7:0] data_out;
		logic [1:0] dir_mode;
		logic [1:0] ack_mode;
		logic       discard_read;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic [7:0] byte_index;
		logic       done_valid;
		logic       done_nack;
		logic       queue_full;
	} out_word_t;

	// queue control from the core
	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctl_t;

	// queue status to the core
	typedef struct packed {
		logic empty;
		logic full;
	} queue_stat_t;

endpackage

@@ src/i2cmts_queue.sv @@
// descriptor fifo with registered head read
module i2cmts_queue import i2cmts_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  queue_ctl_t  ctl,
	input  desc_t       push_desc,
	output desc_t       head_desc,
	output queue_stat_t stat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	desc_t            mem [QUEUE_DEPTH];
	desc_t            head_q;
	logic [PTR_W-1:0] head_ptr_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] head_d;
	logic [PTR_W-1:0] tail_d;

	// pointer advance with wrap
	always_comb begin
		head_d = head_ptr_q;
		tail_d = tail_q;
		if (ctl.pop) begin
			head_d = (head_ptr_q == LAST_PTR) ? '0 : head_ptr_q + 1'b1;
		end
		if (ctl.push) begin
			tail_d = (tail_q == LAST_PTR) ? '0 : tail_q + 1'b1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_ptr_q <= '0;
			tail_q     <= '0;
			count_q    <= '0;
		end else begin
			head_ptr_q <= head_d;
			tail_q     <= tail_d;
			if (ctl.push && !ctl.pop) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.pop && !ctl.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage write
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail_q] <= push_desc;
		end
	end

	// registered read of the next head, with write bypass
	always_ff @(posedge clk) begin
		if (ctl.push && (tail_q == head_d)) begin
			head_q <= push_desc;
		end else begin
			head_q <= mem[head_d];
		end
	end

	assign head_desc  = head_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == FULL_CNT);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !ctl.push)
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> !ctl.pop)
		else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");

endmodule

@@ src/i2cmts_core.sv @@
// sequencer state and per-word decode
module i2cmts_core import i2cmts_pkg::*; #(
	parameter int MAX_LENGTH = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        commit,
	input  in_word_t    word,
	input  desc_t       head_desc,
	input  queue_stat_t qstat,
	output queue_ctl_t  qctl,
	output desc_t       push_desc,
	output out_word_t   result
);

	localparam logic [16:0] MAX_LEN_W = 17'(MAX_LENGTH);

	mode_t      mode_q;
	mode_t      mode_d;
	logic [7:0] bc_q;
	logic [7:0] bc_d;
	desc_t      cur_q;
	desc_t      cur_d;

	desc_t      new_desc;
	desc_t      begin_desc;
	logic       is_ev;
	logic       start_now;
	logic       push;
	logic       drop;
	logic       tx_send;
	logic       finish;
	logic       fin_nack;
	logic       raddr_ok;
	logic       rx_store;
	logic       rx_last;
	logic       rx_nack_next;
	logic       pop;
	logic       do_begin;
	logic [8:0] rx_len;
	logic [8:0] bc_ext;

	// descriptor from the queue word, length clamped
	always_comb begin
		new_desc.address    = word.address;
		new_desc.is_read    = word.is_read;
		new_desc.stop_after = word.stop_after;
		new_desc.length     = word.length;
		if (17'(word.length) > MAX_LEN_W) begin
			new_desc.length = MAX_LEN_W[7:0];
		end
	end

	// decode of the current word against the mode
	always_comb begin
		is_ev     = (word.opcode == OP_EVENT);
		start_now = !is_ev && (mode_q == MODE_IDLE);
		push      = !is_ev && (mode_q != MODE_IDLE) && !qstat.full;
		drop      = !is_ev && (mode_q != MODE_IDLE) && qstat.full;
		bc_ext    = {1'b0, bc_q};
		rx_len    = (cur_q.length == '0) ? 9'd1 : {1'b0, cur_q.length};
		rx_last   = (bc_ext + 9'd1) >= rx_len;
		tx_send   = is_ev && (mode_q == MODE_TX) && (bc_q < cur_q.length) && !word.nack_seen;
		raddr_ok  = is_ev && (mode_q == MODE_RADDR) && !word.nack_seen;
		rx_store  = is_ev && (mode_q == MODE_RX);
		rx_nack_next = rx_store && !rx_last && ((bc_ext + 9'd2) == rx_len);
		finish    = is_ev && (((mode_q == MODE_TX) && !tx_send)
			|| ((mode_q == MODE_RADDR) && word.nack_seen)
			|| ((mode_q == MODE_RX) && rx_last));
		fin_nack  = (mode_q == MODE_RX) ? 1'b0 : word.nack_seen;
		pop       = finish && !qstat.empty;
		do_begin  = start_now || pop;
		begin_desc = start_now ? new_desc : head_desc;
	end

	// next state
	always_comb begin
		mode_d = mode_q;
		bc_d   = bc_q;
		cur_d  = cur_q;
		if (do_begin) begin
			cur_d  = begin_desc;
			bc_d   = '0;
			mode_d = begin_desc.is_read ? MODE_RADDR : MODE_TX;
		end else if (finish) begin
			mode_d = MODE_IDLE;
			bc_d   = '0;
		end else if (tx_send || (rx_store && !rx_last)) begin
			bc_d = bc_q + 8'd1;
		end else if (raddr_ok) begin
			mode_d = MODE_RX;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			bc_q   <= '0;
			cur_q  <= '0;
		end else if (commit) begin
			mode_q <= mode_d;
			bc_q   <= bc_d;
			cur_q  <= cur_d;
		end
	end

	// queue control
	assign qctl.push = commit && push;
	assign qctl.pop  = commit && pop;
	assign push_desc = new_desc;

	// result fields
	always_comb begin
		result = '0;
		if (finish) begin
			result.bus_cmd    = (qstat.empty || cur_q.stop_after) ? BUS_STOP : BUS_RSTART;
			result.done_valid = 1'b1;
			result.done_nack  = fin_nack;
		end
		if (do_begin) begin
			result.data_out_valid = 1'b1;
			result.data_out       = {begin_desc.address, begin_desc.is_read};
			result.dir_mode       = DIR_TX;
			result.ack_mode       = (begin_desc.is_read && (begin_desc.length <= 8'd1))
				? ACK_NACK : ACK_ACK;
		end else if (tx_send) begin
			result.data_out_valid = 1'b1;
			result.data_out       = word.tx_data;
		end else if (rx_nack_next) begin
			result.ack_mode = ACK_NACK;
		end
		if (raddr_ok) begin
			result.dir_mode     = DIR_RX;
			result.discard_read = 1'b1;
		end
		result.rx_valid   = rx_store;
		result.rx_byte    = rx_store ? word.rx_data : '0;
		result.byte_index = rx_store ? bc_q : bc_d;
		result.queue_full = drop;
	end

	a_done_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		result.done_valid |-> (result.bus_cmd != BUS_NONE))
		else $error("completion without bus command");
	a_idle_bc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE) |-> (bc_q == '0))
		else $error("byte counter nonzero while idle");
	a_pop_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		qctl.pop |-> finish)
		else $error("queue pop outside completion");

endmodule

@@ src/i2c_master_transaction_sequencer.sv @@
// A word accepted into the input register is decoded in the next cycle;
// its result word is loaded into the result register once that register has room.
// Throughput: one word per cycle while out_ready holds; the decode is one pass
// and the fifo head is prefetched with a write bypass, so no word waits on another.
// Reset clears mode, byte counter, current descriptor, fifo pointers and the
// valid flags; the fifo storage itself is not cleared.
module i2c_master_transaction_sequencer import i2cmts_pkg::*; #(
	parameter int QUEUE_DEPTH = 4,
	parameter int MAX_LENGTH  = 255
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	logic        valid_s1;
	in_word_t    word_s1;
	logic        advance;
	out_word_t   result;
	out_word_t   out_q;
	logic        out_valid_q;
	queue_ctl_t  qctl;
	queue_stat_t qstat;
	desc_t       push_desc;
	desc_t       head_desc;

	// handshake
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_word;
		end
	end

	i2cmts_core #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.commit   (advance),
		.word     (word_s1),
		.head_desc(head_desc),
		.qstat    (qstat),
		.qctl     (qctl),
		.push_desc(push_desc),
		.result   (result)
	);

	i2cmts_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (qctl),
		.push_desc(push_desc),
		.head_desc(head_desc),
		.stat     (qstat)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> (valid_s1 && (!out_valid_q || out_ready)))
		else $error("result register overwritten");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_q)))
		else $error("stalled result changed");
	a_queue_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(qctl.push && qctl.pop))
		else $error("push and pop in one cycle");

endmodule

@@ tb/sv/i2cmts_sequence_checker.sv @@
`timescale 1ns / 1ps
// checker that predicts every result word of the sequencer and compares it on arrival
module i2cmts_sequence_checker import i2cmts_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_word_t  in_word,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_word_t out_word,
	output int        fail_count,
	output int        pending
);

	// predicted sequencer state
	mode_t       seq_mode;
	int unsigned seq_count;
	desc_t       seq_desc;
	desc_t       held_desc [QUEUE_DEPTH];
	int unsigned held_head;
	int unsigned held_fill;

	// predicted result words still to come, oldest first
	out_word_t   expected_results [$];

	// open the current transfer: address byte out, direction and ack set up
	function automatic void open_transfer(inout out_word_t o);
		seq_count = 0;
		o.data_out_valid = 1'b1;
		o.dir_mode = DIR_TX;
		if (seq_desc.is_read) begin
			seq_mode = MODE_RADDR;
			o.ack_mode = (seq_desc.length <= 8'd1) ? ACK_NACK : ACK_ACK;
			o.data_out = {seq_desc.address, 1'b1};
		end else begin
			seq_mode = MODE_TX;
			o.ack_mode = ACK_ACK;
			o.data_out = {seq_desc.address, 1'b0};
		end
	endfunction

	// close the current transfer and chain into the next held one, if any
	function automatic void close_transfer(inout out_word_t o, input logic nack);
		o.bus_cmd = (held_fill == 0 || seq_desc.stop_after) ? BUS_STOP : BUS_RSTART;
		o.done_valid = 1'b1;
		o.done_nack = nack;
		if (held_fill == 0) begin
			seq_mode = MODE_IDLE;
			seq_count = 0;
		end else begin
			seq_desc = held_desc[held_head];
			held_head = (held_head + 1) % QUEUE_DEPTH;
			held_fill--;
			open_transfer(o);
		end
	endfunction

	// result word caused by one accepted input word
	function automatic out_word_t predict_result(input in_word_t w);
		out_word_t   o;
		desc_t       d;
		int unsigned len;
		logic        stored;
		o = '0;
		stored = 1'b0;
		if (w.opcode == OP_QUEUE) begin
			d.address = w.address;
			d.is_read = w.is_read;
			d.length = w.length;
			d.stop_after = w.stop_after;
			if (seq_mode == MODE_IDLE) begin
				seq_desc = d;
				open_transfer(o);
			end else if (held_fill >= QUEUE_DEPTH) begin
				o.queue_full = 1'b1;
			end else begin
				held_desc[(held_head + held_fill) % QUEUE_DEPTH] = d;
				held_fill++;
			end
		end else begin
			len = seq_desc.length;
			case (seq_mode)
				MODE_TX: begin
					if (seq_count < len) begin
						if (w.nack_seen) begin
							close_transfer(o, 1'b1);
						end else begin
							o.data_out_valid = 1'b1;
							o.data_out = w.tx_data;
							seq_count++;
						end
					end else begin
						close_transfer(o, w.nack_seen);
					end
				end
				MODE_RADDR: begin
					if (w.nack_seen) begin
						close_transfer(o, 1'b1);
					end else begin
						o.dir_mode = DIR_RX;
						o.discard_read = 1'b1;
						seq_mode = MODE_RX;
					end
				end
				MODE_RX: begin
					// zero-length read behaves as a one-byte read
					if (len == 0)
						len = 1;
					o.rx_valid = 1'b1;
					o.rx_byte = w.rx_data;
					o.byte_index = 8'(seq_count);
					stored = 1'b1;
					if (seq_count + 1 >= len) begin
						close_transfer(o, 1'b0);
					end else begin
						if (seq_count + 2 == len)
							o.ack_mode = ACK_NACK;
						seq_count++;
					end
				end
				default: begin
				end
			endcase
		end
		if (!stored)
			o.byte_index = 8'(seq_count);
		return o;
	endfunction

	// one field compare, reported on mismatch
	function automatic int field_differs(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want === got)
			return 0;
		$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		return 1;
	endfunction

	// compare arriving words, then predict for the word taken in at this edge
	always @(posedge clk or negedge arst_n) begin : watch_words
		out_word_t want;
		int        bad;
		if (!arst_n) begin
			seq_mode = MODE_IDLE;
			seq_count = 0;
			seq_desc = '0;
			held_head = 0;
			held_fill = 0;
			expected_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result word, expected none actual %h",
						$time, out_word);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					bad = field_differs("bus_cmd", want.bus_cmd, out_word.bus_cmd)
						+ field_differs("data_out_valid", want.data_out_valid,
							out_word.data_out_valid)
						+ field_differs("data_out", want.data_out, out_word.data_out)
						+ field_differs("dir_mode", want.dir_mode, out_word.dir_mode)
						+ field_differs("ack_mode", want.ack_mode, out_word.ack_mode)
						+ field_differs("discard_read", want.discard_read,
							out_word.discard_read)
						+ field_differs("rx_valid", want.rx_valid, out_word.rx_valid)
						+ field_differs("rx_byte", want.rx_byte, out_word.rx_byte)
						+ field_differs("byte_index", want.byte_index, out_word.byte_index)
						+ field_differs("done_valid", want.done_valid, out_word.done_valid)
						+ field_differs("done_nack", want.done_nack, out_word.done_nack)
						+ field_differs("queue_full", want.queue_full, out_word.queue_full);
					fail_count += bad;
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(predict_result(in_word));
			pending = expected_results.size();
		end
	end

endmodule

@@ tb/sv/i2c_master_transaction_sequencer_test.sv @@
`timescale 1ns / 1ps
// top of the sequencer testbench: clock, reset, word traffic and the verdict
module i2c_master_transaction_sequencer_test import i2cmts_pkg::*;;

	localparam int ITEM_TARGET = 1750;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_word;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_word;
	int        fail_count;
	int        pending;
	int        items_sent;
	bit        calm;

	i2c_master_transaction_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	i2cmts_sequence_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_word    (in_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_word   (out_word),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop if the run hangs
	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	// idle length: mostly none or short, a few long, none in calm stretches
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 2);
		if (r < 97)
			return $urandom_range(3, 6);
		return $urandom_range(10, 30);
	endfunction

	// transfer length: mostly tiny, some medium, rarely with the top bit set
	function automatic logic [7:0] pick_length();
		int r;
		r = $urandom_range(0, 199);
		if (r == 0)
			return 8'd255;
		if (r < 3)
			return 8'($urandom_range(128, 255));
		if (r < 16)
			return 8'($urandom_range(5, 40));
		return 8'($urandom_range(0, 4));
	endfunction

	function automatic in_word_t random_word();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[$bits(in_word_t)-1:0];
	endfunction

	// present one word after a random gap and hold it until taken
	task automatic send_word(input in_word_t w);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic queue_xfer(input logic [6:0] addr, input logic rd, input logic [7:0] len,
			input logic stop);
		in_word_t w;
		w = random_word();
		w.opcode = OP_QUEUE;
		w.address = addr;
		w.is_read = rd;
		w.length = len;
		w.stop_after = stop;
		send_word(w);
	endtask

	task automatic byte_event(input logic nack, input logic [7:0] rx, input logic [7:0] tx);
		in_word_t w;
		w = random_word();
		w.opcode = OP_EVENT;
		w.nack_seen = nack;
		w.rx_data = rx;
		w.tx_data = tx;
		send_word(w);
	endtask

	// stop sending until every predicted word has come back
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// a group of queued transfers followed by roughly the events they need
	task automatic run_burst();
		int         n_xfer;
		int         n_evt;
		logic [7:0] len;
		n_xfer = $urandom_range(1, 6);
		n_evt = $urandom_range(0, 2);
		repeat (n_xfer) begin
			len = pick_length();
			queue_xfer(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), len,
				$urandom_range(0, 3) == 0);
			n_evt += ((len == 0) ? 1 : int'(len)) + 2;
		end
		// now and then cut the events short so a transfer is left mid-way
		if ($urandom_range(0, 7) == 0)
			n_evt = $urandom_range(0, n_evt);
		repeat (n_evt) begin
			if ($urandom_range(0, 49) == 0)
				queue_xfer(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
					pick_length(), $urandom_range(0, 3) == 0);
			else
				byte_event($urandom_range(0, 99) < 5, 8'($urandom()), 8'($urandom()));
		end
	endtask

	// result side: ready runs broken by random stalls
	initial begin : result_side
		int run;
		int hold;
		out_ready = 1'b0;
		forever begin
			run = $urandom_range(1, 24);
			hold = pick_gap();
			repeat (run) begin
				@(negedge clk);
				out_ready <= 1'b1;
			end
			repeat (hold) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
		end
	end

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		items_sent = 0;
		calm = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// event with nothing running is ignored
		byte_event(1'b0, 8'hFF, 8'hFF);
		// fill the fifo behind a running write, then overflow it
		queue_xfer(7'h7F, 1'b0, 8'd0, 1'b0);
		queue_xfer(7'h00, 1'b1, 8'd0, 1'b1);
		queue_xfer(7'h55, 1'b0, 8'd1, 1'b0);
		queue_xfer(7'h2A, 1'b1, 8'd2, 1'b0);
		queue_xfer(7'h01, 1'b0, 8'd255, 1'b1);
		queue_xfer(7'h7F, 1'b1, 8'd255, 1'b1);
		// empty write ends with repeated start into a zero-length read
		byte_event(1'b0, 8'h00, 8'h00);
		byte_event(1'b0, 8'h00, 8'h00);
		byte_event(1'b0, 8'hFF, 8'h00);
		// one-byte write closed by a nack, then a two-byte read
		byte_event(1'b0, 8'h00, 8'hFF);
		byte_event(1'b1, 8'h00, 8'h00);
		byte_event(1'b0, 8'h00, 8'h00);
		byte_event(1'b0, 8'h00, 8'h00);
		byte_event(1'b0, 8'hA5, 8'h00);
		// long write cut by a nack with nothing held behind it
		byte_event(1'b0, 8'h00, 8'h00);
		byte_event(1'b1, 8'hFF, 8'hFF);
		// one-byte read refused at the address
		queue_xfer(7'h03, 1'b1, 8'd1, 1'b0);
		byte_event(1'b1, 8'h00, 8'h00);
		// three-byte read with the nack set up before the last byte
		queue_xfer(7'h40, 1'b1, 8'd3, 1'b0);
		byte_event(1'b0, 8'h00, 8'h00);
		byte_event(1'b0, 8'h5A, 8'h00);
		byte_event(1'b0, 8'hC3, 8'h00);
		byte_event(1'b0, 8'h3C, 8'h00);
		drain_results();

		// random traffic
		while (items_sent < ITEM_TARGET) begin
			calm = ($urandom_range(0, 9) == 0);
			if ($urandom_range(0, 19) == 0)
				drain_results();
			if ($urandom_range(0, 19) == 0)
				repeat ($urandom_range(1, 4)) send_word(random_word());
			else
				run_burst();
		end
		calm = 1'b0;
		drain_results();
		repeat (8) @(negedge clk);

		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
